@@ src/wspa_pkg.sv @@
// types and constants for the watch slot pool allocator
// no dependencies; imported by watch_slot_pool_allocator
package wspa_pkg;

    localparam int FUNC_W   = 2;
    localparam int NUM_W    = 5;
    localparam int CNT_W    = 6;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_LIST    = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STS_POOL_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_ACTIVE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NO_ACTIVE  = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_ALLOC    = 7'b0000010,
        ST_REL_RD   = 7'b0000100,
        ST_REL_FIX  = 7'b0001000,
        ST_REL_PUSH = 7'b0010000,
        ST_LIST     = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } state_t;

endpackage

@@ src/watch_slot_pool_allocator.sv @@
// slot pool allocator: lifo free list and newest-first active list in one link memory
// depends on wspa_pkg
// steps: lookup goes straight to the result; allocate reads the free head link, then relinks;
// release walks to the slot, relinks when it is not the head, then frees it; list emits
// one beat per cycle while m_tready allows; one item at a time, and release walks the link
// memory at one entry per cycle
// reset: free list 0,1,2,... and active list empty at once; link memory is not cleared,
// entries never written read as the next slot through per-entry valid bits
module watch_slot_pool_allocator #(
    parameter int POOL_SIZE = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wspa_pkg::S_DATA_W-1:0] s_tdata,   // requested_number
    input  logic [wspa_pkg::FUNC_W-1:0]   s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wspa_pkg::M_DATA_W-1:0] m_tdata,   // result_number, active_count
    output logic [wspa_pkg::STATUS_W-1:0] m_tuser,   // status
    output logic                          m_tlast
);
    import wspa_pkg::*;

    localparam int IDX_W  = (POOL_SIZE > 2) ? $clog2(POOL_SIZE) : 1;
    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

    logic [LINK_W-1:0] link_mem [POOL_SIZE];

    state_t                state_reg, state_next;
    logic [LINK_W-1:0]     free_head_reg, free_head_next;
    logic [LINK_W-1:0]     active_head_reg, active_head_next;
    logic [LINK_W-1:0]     total_reg, total_next;
    logic [POOL_SIZE-1:0]  active_flags_reg, active_flags_next;
    logic [POOL_SIZE-1:0]  link_valid_reg, link_valid_next;
    logic                  out_valid_reg, out_valid_next;

    logic [LINK_W-1:0]     cur_reg, cur_next;
    logic [LINK_W-1:0]     prev_reg, prev_next;
    logic [LINK_W-1:0]     nxt_reg, nxt_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      req_idx_reg, req_idx_next;
    logic [NUM_W-1:0]      req_num_reg, req_num_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [NUM_W-1:0]      res_num_reg, res_num_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [NUM_W-1:0]      out_num_reg, out_num_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;

    logic [LINK_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_addr_reg;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [LINK_W-1:0]     wr_data;

    logic [LINK_W-1:0]     link_rd;
    logic                  out_free;
    logic                  in_beat;
    logic [IDX_W+NUM_W-1:0] req_ext;
    logic [IDX_W-1:0]      req_idx;
    logic                  req_in_range;
    logic                  req_active;
    logic [LINK_W+NUM_W-1:0] head_ext;
    logic [LINK_W+NUM_W-1:0] cur_ext;
    logic [LINK_W+CNT_W-1:0] total_ext;
    logic                  list_fin;

    assign link_rd      = rd_valid_reg ? rd_data_reg : LINK_W'(rd_addr_reg) + LINK_W'(1);
    assign out_free     = !out_valid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE);
    assign in_beat      = s_tvalid && s_tready;
    assign req_ext      = {{IDX_W{1'b0}}, s_tdata[NUM_W-1:0]};
    assign req_idx      = req_ext[IDX_W-1:0];
    assign req_in_range = req_ext < (IDX_W + NUM_W)'(POOL_SIZE);
    assign req_active   = req_in_range && active_flags_reg[req_idx];
    assign head_ext     = {{NUM_W{1'b0}}, free_head_reg};
    assign cur_ext      = {{NUM_W{1'b0}}, cur_reg};
    assign total_ext    = {{CNT_W{1'b0}}, total_reg};
    assign list_fin     = (link_rd == NIL) || (k_reg == IDX_W'(POOL_SIZE - 1));

    always_comb
    begin
        state_next        = state_reg;
        free_head_next    = free_head_reg;
        active_head_next  = active_head_reg;
        total_next        = total_reg;
        active_flags_next = active_flags_reg;
        link_valid_next   = link_valid_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        cur_next          = cur_reg;
        prev_next         = prev_reg;
        nxt_next          = nxt_reg;
        k_next            = k_reg;
        req_idx_next      = req_idx_reg;
        req_num_next      = req_num_reg;
        res_status_next   = res_status_reg;
        res_num_next      = res_num_reg;
        out_status_next   = out_status_reg;
        out_num_next      = out_num_reg;
        out_count_next    = out_count_reg;
        out_last_next     = out_last_reg;
        rd_en             = 1'b0;
        rd_addr           = cur_reg[IDX_W-1:0];
        mem_we            = 1'b0;
        wr_addr           = req_idx_reg;
        wr_data           = free_head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    req_idx_next = req_idx;
                    req_num_next = s_tdata[NUM_W-1:0];
                    state_next   = ST_EMIT;
                    case (s_tuser)
                        FN_ALLOC:
                        begin
                            if (free_head_reg == NIL)
                            begin
                                res_status_next = STS_POOL_EMPTY;
                                res_num_next    = '0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = free_head_reg[IDX_W-1:0];
                                state_next = ST_ALLOC;
                            end
                        end
                        FN_RELEASE:
                        begin
                            if (!req_active)
                            begin
                                res_status_next = STS_NOT_ACTIVE;
                                res_num_next    = s_tdata[NUM_W-1:0];
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = active_head_reg[IDX_W-1:0];
                                cur_next   = active_head_reg;
                                prev_next  = NIL;
                                state_next = ST_REL_RD;
                            end
                        end
                        FN_LOOKUP:
                        begin
                            res_status_next = req_active ? STS_OK : STS_NOT_ACTIVE;
                            res_num_next    = s_tdata[NUM_W-1:0];
                        end
                        FN_LIST:
                        begin
                            if (active_head_reg == NIL)
                            begin
                                res_status_next = STS_NO_ACTIVE;
                                res_num_next    = '0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = active_head_reg[IDX_W-1:0];
                                cur_next   = active_head_reg;
                                k_next     = '0;
                                state_next = ST_LIST;
                            end
                        end
                        default:
                        begin
                            res_status_next = STS_NOT_ACTIVE;
                            res_num_next    = s_tdata[NUM_W-1:0];
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                // pop free head, push it on the active head
                mem_we           = 1'b1;
                wr_addr          = free_head_reg[IDX_W-1:0];
                wr_data          = active_head_reg;
                link_valid_next[free_head_reg[IDX_W-1:0]]   = 1'b1;
                active_flags_next[free_head_reg[IDX_W-1:0]] = 1'b1;
                free_head_next   = link_rd;
                active_head_next = free_head_reg;
                total_next       = total_reg + LINK_W'(1);
                res_status_next  = STS_OK;
                res_num_next     = head_ext[NUM_W-1:0];
                state_next       = ST_EMIT;
            end
            ST_REL_RD:
            begin
                if (cur_reg == LINK_W'(req_idx_reg))
                begin
                    nxt_next = link_rd;
                    if (prev_reg == NIL)
                    begin
                        state_next = ST_REL_PUSH;
                    end
                    else
                    begin
                        state_next = ST_REL_FIX;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    rd_en     = 1'b1;
                    rd_addr   = link_rd[IDX_W-1:0];
                end
            end
            ST_REL_FIX:
            begin
                mem_we     = 1'b1;
                wr_addr    = prev_reg[IDX_W-1:0];
                wr_data    = nxt_reg;
                link_valid_next[prev_reg[IDX_W-1:0]] = 1'b1;
                state_next = ST_REL_PUSH;
            end
            ST_REL_PUSH:
            begin
                mem_we          = 1'b1;
                wr_addr         = req_idx_reg;
                wr_data         = free_head_reg;
                link_valid_next[req_idx_reg]   = 1'b1;
                active_flags_next[req_idx_reg] = 1'b0;
                free_head_next  = LINK_W'(req_idx_reg);
                if (prev_reg == NIL)
                begin
                    active_head_next = nxt_reg;
                end
                if (total_reg != '0)
                begin
                    total_next = total_reg - LINK_W'(1);
                end
                res_status_next = STS_OK;
                res_num_next    = req_num_reg;
                state_next      = ST_EMIT;
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STS_OK;
                    out_num_next    = cur_ext[NUM_W-1:0];
                    out_count_next  = total_ext[CNT_W-1:0];
                    out_last_next   = list_fin;
                    if (list_fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next = link_rd;
                        k_next   = k_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = link_rd[IDX_W-1:0];
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_num_next    = res_num_reg;
                    out_count_next  = total_ext[CNT_W-1:0];
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            free_head_reg    <= '0;
            active_head_reg  <= NIL;
            total_reg        <= '0;
            active_flags_reg <= '0;
            link_valid_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_head_reg    <= free_head_next;
            active_head_reg  <= active_head_next;
            total_reg        <= total_next;
            active_flags_reg <= active_flags_next;
            link_valid_reg   <= link_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        k_reg          <= k_next;
        req_idx_reg    <= req_idx_next;
        req_num_reg    <= req_num_next;
        res_status_reg <= res_status_next;
        res_num_reg    <= res_num_next;
        out_status_reg <= out_status_next;
        out_num_reg    <= out_num_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    // link memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= link_mem[rd_addr];
            rd_valid_reg <= link_valid_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_DATA_W - NUM_W - CNT_W){1'b0}}, out_count_reg, out_num_reg};
    assign m_tlast  = out_last_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= LINK_W'(POOL_SIZE))
        else $error("active total beyond pool size");

    a_flags_match_total: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_flags_reg) == int'(total_reg))
        else $error("active flags disagree with active total");

    a_free_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == NIL) == (total_reg == LINK_W'(POOL_SIZE)))
        else $error("free list empty state disagrees with active total");

    a_active_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (active_head_reg == NIL) == (total_reg == '0))
        else $error("active list empty state disagrees with active total");

    a_walk_not_nil: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REL_RD) |-> (cur_reg != NIL))
        else $error("release walk ran off the active list");

endmodule

@@ dv/watch_slot_pool_allocator_tb.sv @@
// self-checking testbench for the watch slot pool allocator: directed table, then biased random
// depends on wspa_pkg and watch_slot_pool_allocator; a behavioural pool model predicts the beats of untyped items
`timescale 1ns / 1ps

module watch_slot_pool_allocator_tb;
    import wspa_pkg::*;

    localparam int POOL_SIZE      = 32;
    localparam logic [5:0] NIL    = 6'd32;
    localparam int RANDOM_ITEMS   = 330;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUM_W-1:0]    number;
        logic [CNT_W-1:0]    count;
        logic                last;
    } beat_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [NUM_W-1:0]  number;
        int                reps;
        bit                typed;
        beat_t             want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tlast;

    // pool model state
    logic [5:0]          slot_link [POOL_SIZE];
    logic [5:0]          free_top;
    logic [5:0]          active_top;
    bit                  in_use [POOL_SIZE];
    logic [CNT_W-1:0]    active_total;

    beat_t               pending_beats [$];
    int                  errors = 0;
    int                  quiet_cycles = 0;
    int                  hold_left = 0;
    bit                  calm = 1'b0;
    bit                  filling = 1'b1;

    // typed rows carry the beat read straight off the pool behaviour
    dir_row_t directed_rows [23] = '{
        '{FN_LIST,    5'd0,  1,  1'b1, '{STS_NO_ACTIVE,  5'd0,  6'd0,  1'b1}},
        '{FN_ALLOC,   5'd0,  1,  1'b1, '{STS_OK,         5'd0,  6'd1,  1'b1}},
        '{FN_LOOKUP,  5'd0,  1,  1'b1, '{STS_OK,         5'd0,  6'd1,  1'b1}},
        '{FN_LOOKUP,  5'd31, 1,  1'b1, '{STS_NOT_ACTIVE, 5'd31, 6'd1,  1'b1}},
        '{FN_RELEASE, 5'd31, 1,  1'b1, '{STS_NOT_ACTIVE, 5'd31, 6'd1,  1'b1}},
        '{FN_RELEASE, 5'd0,  1,  1'b1, '{STS_OK,         5'd0,  6'd0,  1'b1}},
        '{FN_LIST,    5'd31, 1,  1'b1, '{STS_NO_ACTIVE,  5'd0,  6'd0,  1'b1}},
        '{FN_ALLOC,   5'd31, 1,  1'b1, '{STS_OK,         5'd0,  6'd1,  1'b1}},
        '{FN_ALLOC,   5'd0,  30, 1'b0, '0},
        '{FN_ALLOC,   5'd0,  1,  1'b1, '{STS_OK,         5'd31, 6'd32, 1'b1}},
        '{FN_ALLOC,   5'd0,  1,  1'b1, '{STS_POOL_EMPTY, 5'd0,  6'd32, 1'b1}},
        '{FN_LIST,    5'd0,  1,  1'b0, '0},
        '{FN_RELEASE, 5'd15, 1,  1'b1, '{STS_OK,         5'd15, 6'd31, 1'b1}},
        '{FN_RELEASE, 5'd31, 1,  1'b1, '{STS_OK,         5'd31, 6'd30, 1'b1}},
        '{FN_RELEASE, 5'd0,  1,  1'b1, '{STS_OK,         5'd0,  6'd29, 1'b1}},
        '{FN_LOOKUP,  5'd15, 1,  1'b1, '{STS_NOT_ACTIVE, 5'd15, 6'd29, 1'b1}},
        '{FN_LIST,    5'd0,  1,  1'b0, '0},
        '{FN_ALLOC,   5'd0,  1,  1'b1, '{STS_OK,         5'd0,  6'd30, 1'b1}},
        '{FN_ALLOC,   5'd0,  1,  1'b1, '{STS_OK,         5'd31, 6'd31, 1'b1}},
        '{FN_ALLOC,   5'd0,  1,  1'b1, '{STS_OK,         5'd15, 6'd32, 1'b1}},
        '{FN_ALLOC,   5'd0,  1,  1'b1, '{STS_POOL_EMPTY, 5'd0,  6'd32, 1'b1}},
        '{FN_RELEASE, 5'd10, 1,  1'b0, '0},
        '{FN_LOOKUP,  5'd10, 1,  1'b1, '{STS_NOT_ACTIVE, 5'd10, 6'd31, 1'b1}}
    };

    watch_slot_pool_allocator #(
        .POOL_SIZE (POOL_SIZE)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic int idle_length();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    task automatic clear_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            slot_link[i] = 6'(i + 1);
            in_use[i]    = 1'b0;
        end
        free_top     = 6'd0;
        active_top   = NIL;
        active_total = '0;
    endtask

    task automatic note_beat(input bit record, input logic [STATUS_W-1:0] st,
                             input logic [NUM_W-1:0] num, input bit fin);
        if (record)
            pending_beats.push_back('{st, num, active_total, fin});
    endtask

    // advances the pool by one accepted beat and, if asked, queues the beats it produces
    task automatic pool_step(input logic [FUNC_W-1:0] f, input logic [NUM_W-1:0] n,
                             input bit record);
        logic [5:0] s;
        logic [5:0] cur;
        logic [5:0] prev;
        logic [5:0] nxt;
        int         k;
        case (f)
            FN_ALLOC:
            begin
                if (free_top >= NIL)
                    note_beat(record, STS_POOL_EMPTY, '0, 1'b1);
                else
                begin
                    s                  = free_top;
                    free_top           = slot_link[s[4:0]];
                    slot_link[s[4:0]]  = active_top;
                    active_top         = s;
                    in_use[s[4:0]]     = 1'b1;
                    active_total       = active_total + 1'b1;
                    note_beat(record, STS_OK, s[4:0], 1'b1);
                end
            end
            FN_RELEASE:
            begin
                if (!in_use[n])
                    note_beat(record, STS_NOT_ACTIVE, n, 1'b1);
                else
                begin
                    cur  = active_top;
                    prev = NIL;
                    for (k = 0; k < POOL_SIZE; k++)
                    begin
                        if (cur >= NIL || cur == {1'b0, n})
                            break;
                        prev = cur;
                        cur  = slot_link[cur[4:0]];
                    end
                    if (cur == {1'b0, n})
                    begin
                        if (prev == NIL)
                            active_top = slot_link[n];
                        else
                            slot_link[prev[4:0]] = slot_link[n];
                    end
                    slot_link[n] = free_top;
                    free_top     = {1'b0, n};
                    in_use[n]    = 1'b0;
                    if (active_total > 0)
                        active_total = active_total - 1'b1;
                    note_beat(record, STS_OK, n, 1'b1);
                end
            end
            FN_LOOKUP:
                note_beat(record, in_use[n] ? STS_OK : STS_NOT_ACTIVE, n, 1'b1);
            default:
            begin
                if (active_top >= NIL)
                    note_beat(record, STS_NO_ACTIVE, '0, 1'b1);
                else
                begin
                    cur = active_top;
                    k   = 0;
                    while (cur < NIL && k < POOL_SIZE)
                    begin
                        nxt = slot_link[cur[4:0]];
                        note_beat(record, STS_OK, cur[4:0], (nxt >= NIL) || (k + 1 >= POOL_SIZE));
                        k++;
                        cur = nxt;
                    end
                end
            end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic drive_item(input logic [FUNC_W-1:0] f, input logic [NUM_W-1:0] n,
                              input bit typed, input beat_t want);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(S_DATA_W - NUM_W){1'b0}}, n};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (typed)
            pending_beats.push_back(want);
        pool_step(f, n, !typed);
        @(negedge clk);
    endtask

    task automatic pick_random_item(output logic [FUNC_W-1:0] f, output logic [NUM_W-1:0] n);
        int r;
        int live [$];
        r = $urandom_range(99, 0);
        for (int i = 0; i < POOL_SIZE; i++)
            if (in_use[i])
                live.push_back(i);
        n = NUM_W'($urandom_range(POOL_SIZE - 1, 0));
        if (r < (filling ? 65 : 25))
            f = FN_ALLOC;
        else if (r < 80)
        begin
            f = FN_RELEASE;
            if (live.size() > 0 && $urandom_range(3, 0) != 0)
                n = NUM_W'(live[$urandom_range(live.size() - 1, 0)]);
        end
        else if (r < 93)
        begin
            f = FN_LOOKUP;
            if (live.size() > 0 && $urandom_range(1, 0) != 0)
                n = NUM_W'(live[$urandom_range(live.size() - 1, 0)]);
        end
        else
            f = FN_LIST;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready  <= 1'b1;
            hold_left <= idle_length();
        end
    end

    always @(posedge clk)
    begin : result_check
        beat_t seen;
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = '{m_tuser, m_tdata[NUM_W-1:0], m_tdata[NUM_W+CNT_W-1:NUM_W], m_tlast};
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat: status %0d number %0d count %0d last %0d",
                       seen.status, seen.number, seen.count, seen.last);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (seen.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, seen.status);
                    errors++;
                end
                if (seen.number !== want.number)
                begin
                    $error("result_number: expected %0d, got %0d", want.number, seen.number);
                    errors++;
                end
                if (seen.count !== want.count)
                begin
                    $error("active_count: expected %0d, got %0d", want.count, seen.count);
                    errors++;
                end
                if (seen.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, seen.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watch_slot_pool_allocator verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [FUNC_W-1:0] f;
        logic [NUM_W-1:0]  n;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FN_ALLOC;
        clear_pool();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            for (int r = 0; r < directed_rows[i].reps; r++)
                drive_item(directed_rows[i].func, directed_rows[i].number,
                           directed_rows[i].typed, directed_rows[i].want);

        // each phase picks filling or draining the pool at random, some without idling
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                filling = $urandom_range(1, 0);
                calm    = ($urandom_range(3, 0) == 0);
            end
            pick_random_item(f, n);
            drive_item(f, n, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("watch_slot_pool_allocator verification clean");
        else
            $display("watch_slot_pool_allocator verification failed");
        $finish;
    end

endmodule
